/* design/dpb_pkg.sv */
`timescale 1ns / 1ps
// dpb_pkg: shared types, widths and helper functions of the depth pixel
// back-projection block. No dependencies.
package dpb_pkg;

  localparam int MAX_DIM         = 4096;
  localparam int RECIP_FRAC_BITS = 24;

  localparam int DEPTH_W = 16;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int RECIP_W = 24;
  localparam int CTR_W   = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_DW  = 24;
  localparam int CFG_IW  = 3;

  localparam int SCALE_W = 22;
  localparam logic [SCALE_W-1:0] SCALE_Q24 = 22'd2423368;
  localparam int ZF_W    = DEPTH_W + SCALE_W;
  localparam int Z8_SHIFT = 16;
  localparam int Z8_W    = ZF_W - Z8_SHIFT;
  localparam int Z_W     = 14;
  localparam int MAG_W   = 16;
  localparam int A_W     = MAG_W + RECIP_W;
  localparam int HALF_W  = A_W / 2;
  localparam int PP_W    = HALF_W + Z8_W;
  localparam int PROD_W  = A_W + Z8_W;
  localparam int XY_SHIFT = 4 + RECIP_FRAC_BITS + 8;
  localparam int Q_W     = PROD_W - XY_SHIFT;
  localparam int OUT_W   = 21;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IW-1:0] {
    CFG_INV_FOCAL_X  = 3'd0,
    CFG_INV_FOCAL_Y  = 3'd1,
    CFG_CENTRE_X     = 3'd2,
    CFG_CENTRE_Y     = 3'd3,
    CFG_FRAME_WIDTH  = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZMUL,
    ST_AMUL,
    ST_PLO,
    ST_PHI,
    ST_SUM,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } dpb_item_t;

  typedef struct packed {
    logic [RECIP_W-1:0] inv_fx;
    logic [RECIP_W-1:0] inv_fy;
    logic [CTR_W-1:0]   cx;
    logic [CTR_W-1:0]   cy;
  } cam_cfg_t;

  function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // floor of signed product over 2^XY_SHIFT, saturated to OUT_W bits
  function automatic logic [OUT_W-1:0] sat_coord(input logic [PROD_W-1:0] prod,
                                                  input logic neg);
    logic [Q_W-1:0] q;
    logic           frac;
    logic [Q_W:0]   qn;
    logic [OUT_W-1:0] r;
    q    = prod[PROD_W-1:XY_SHIFT];
    frac = |prod[XY_SHIFT-1:0];
    qn   = {1'b0, q} + {{Q_W{1'b0}}, frac};
    if (neg) begin
      if (qn > (Q_W+1)'(1 << (OUT_W - 1))) begin
        r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        r = ~qn[OUT_W-1:0] + OUT_W'(1);
      end
    end else begin
      if (q > Q_W'((1 << (OUT_W - 1)) - 1)) begin
        r = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        r = q[OUT_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

/* design/dpb_front.sv */
`timescale 1ns / 1ps
// dpb_front: input acceptance, raster counters and mask filtering.
// Depends on dpb_pkg; feeds dpb_queue.
module dpb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dpb_pkg::DEPTH_W-1:0]  in_depth_raw,
  input  logic                         in_keep_pixel,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_red,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_green,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_blue,
  input  logic [dpb_pkg::DIM_W-1:0]    frame_width,
  input  logic [dpb_pkg::DIM_W-1:0]    frame_height,
  input  logic                         q_full,
  output logic                         q_push,
  output dpb_pkg::dpb_item_t           q_item
);
  import dpb_pkg::*;

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0]   wl, hl;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_keep_pixel;

  assign q_item.depth = in_depth_raw;
  assign q_item.col   = col_r;
  assign q_item.row   = row_r;
  assign q_item.red   = in_red;
  assign q_item.green = in_green;
  assign q_item.blue  = in_blue;

  assign wl      = dim_limit(frame_width);
  assign hl      = dim_limit(frame_height);
  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= wl) begin
        col_nxt = '0;
        row_nxt = (row_inc >= hl) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_nxt = col_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* design/dpb_queue.sv */
`timescale 1ns / 1ps
// dpb_queue: short FIFO of kept pixels between front and back.
// Depends on dpb_pkg.
module dpb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dpb_pkg::dpb_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output dpb_pkg::dpb_item_t pop_item
);
  import dpb_pkg::*;

  dpb_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* design/dpb_back.sv */
`timescale 1ns / 1ps
// dpb_back: multi-step projection sequencer and output register.
// Depends on dpb_pkg; drains dpb_queue.
module dpb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dpb_pkg::cam_cfg_t            cam,
  input  logic                         q_valid,
  input  dpb_pkg::dpb_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpb_pkg::OUT_W-1:0]    out_point_x,
  output logic [dpb_pkg::OUT_W-1:0]    out_point_y,
  output logic [dpb_pkg::Z_W-1:0]      out_point_z,
  output logic [dpb_pkg::COLOR_W-1:0]  out_red,
  output logic [dpb_pkg::COLOR_W-1:0]  out_green,
  output logic [dpb_pkg::COLOR_W-1:0]  out_blue
);
  import dpb_pkg::*;

  back_state_t state_r, state_nxt;

  dpb_item_t         item_r;
  logic [ZF_W-1:0]   zf_r;
  logic              negx_r, negy_r;
  logic [MAG_W-1:0]  magx_r, magy_r;
  logic [A_W-1:0]    ax_r, ay_r;
  logic [PP_W-1:0]   plx_r, ply_r, phx_r, phy_r;
  logic [PROD_W-1:0] prodx_r, prody_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  px_r, py_r;
  logic [Z_W-1:0]    pz_r;
  logic [COLOR_W-1:0] r_r, g_r, b_r;

  logic [MAG_W:0]    dx, dy;
  logic [Z8_W-1:0]   z8;
  logic              out_free;
  logic              ld_item, ld_out;

  assign dx  = {1'b0, item_r.col, 4'b0} - {1'b0, cam.cx};
  assign dy  = {1'b0, item_r.row, 4'b0} - {1'b0, cam.cy};
  assign z8  = zf_r[ZF_W-1:Z8_SHIFT];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_ZMUL;
      ST_ZMUL: state_nxt = ST_AMUL;
      ST_AMUL: state_nxt = ST_PLO;
      ST_PLO:  state_nxt = ST_PHI;
      ST_PHI:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ld_item = 1'b0;
    ld_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: ld_item = q_valid;
      ST_OUT:  ld_out  = out_free;
      default: begin
        ld_item = 1'b0;
        ld_out  = 1'b0;
      end
    endcase
  end

  assign q_pop = ld_item;

  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      item_r <= q_item;
    end
    if (state_r == ST_ZMUL) begin
      zf_r   <= ZF_W'(item_r.depth * SCALE_Q24);
      negx_r <= dx[MAG_W];
      negy_r <= dy[MAG_W];
      magx_r <= dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      magy_r <= dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    end
    if (state_r == ST_AMUL) begin
      ax_r <= A_W'(magx_r * cam.inv_fx);
      ay_r <= A_W'(magy_r * cam.inv_fy);
    end
    if (state_r == ST_PLO) begin
      plx_r <= PP_W'(ax_r[HALF_W-1:0] * z8);
      ply_r <= PP_W'(ay_r[HALF_W-1:0] * z8);
    end
    if (state_r == ST_PHI) begin
      phx_r <= PP_W'(ax_r[A_W-1:HALF_W] * z8);
      phy_r <= PP_W'(ay_r[A_W-1:HALF_W] * z8);
    end
    if (state_r == ST_SUM) begin
      prodx_r <= {phx_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plx_r};
      prody_r <= {phy_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, ply_r};
    end
    if (ld_out) begin
      px_r <= sat_coord(prodx_r, negx_r);
      py_r <= sat_coord(prody_r, negy_r);
      pz_r <= zf_r[ZF_W-1:ZF_W-Z_W];
      r_r  <= item_r.red;
      g_r  <= item_r.green;
      b_r  <= item_r.blue;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;
  assign out_point_z = pz_r;
  assign out_red     = r_r;
  assign out_green   = g_r;
  assign out_blue    = b_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue drained outside idle");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("result not presented after final step");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_z <= Z_W'(9466)))
    else $error("depth coordinate out of range");

endmodule

/* design/depth_pixel_backprojection.sv */
`timescale 1ns / 1ps
// Depth pixel back-projection top level: configuration registers, front, queue, back.
// Throughput: masked pixels one per cycle while the queue is not full. The back
// sequencer works on one kept pixel at a time and pops the next only after its multiply
// steps and output register load; a 4-entry queue absorbs bursts of kept pixels.
// Reset (rst_n low, synchronous): counters zero, queue empty, output invalid,
// registers to their defaults. No clearing pass.
module depth_pixel_backprojection (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [dpb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [dpb_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dpb_pkg::DEPTH_W-1:0]  in_depth_raw,
  input  logic                         in_keep_pixel,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_red,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_green,
  input  logic [dpb_pkg::COLOR_W-1:0]  in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpb_pkg::OUT_W-1:0]    out_point_x,
  output logic [dpb_pkg::OUT_W-1:0]    out_point_y,
  output logic [dpb_pkg::Z_W-1:0]      out_point_z,
  output logic [dpb_pkg::COLOR_W-1:0]  out_red,
  output logic [dpb_pkg::COLOR_W-1:0]  out_green,
  output logic [dpb_pkg::COLOR_W-1:0]  out_blue
);
  import dpb_pkg::*;

  cam_cfg_t         cam_r, cam_nxt;
  logic [DIM_W-1:0] fw_r, fw_nxt;
  logic [DIM_W-1:0] fh_r, fh_nxt;

  logic      q_full, q_push, q_pop, q_valid;
  dpb_item_t q_in, q_out;

  always_comb begin
    cam_nxt = cam_r;
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_INV_FOCAL_X:  cam_nxt.inv_fx = cfg_data[RECIP_W-1:0];
        CFG_INV_FOCAL_Y:  cam_nxt.inv_fy = cfg_data[RECIP_W-1:0];
        CFG_CENTRE_X:     cam_nxt.cx     = cfg_data[CTR_W-1:0];
        CFG_CENTRE_Y:     cam_nxt.cy     = cfg_data[CTR_W-1:0];
        CFG_FRAME_WIDTH:  fw_nxt         = cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_nxt         = cfg_data[DIM_W-1:0];
        default: begin
          cam_nxt = cam_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.inv_fx <= RECIP_W'(27962);
      cam_r.inv_fy <= RECIP_W'(27962);
      cam_r.cx     <= CTR_W'(5120);
      cam_r.cy     <= CTR_W'(3840);
      fw_r         <= DIM_W'(640);
      fh_r         <= DIM_W'(480);
    end else begin
      cam_r <= cam_nxt;
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
    end
  end

  dpb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_depth_raw  (in_depth_raw),
    .in_keep_pixel (in_keep_pixel),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .frame_width   (fw_r),
    .frame_height  (fh_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  dpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_out)
  );

  dpb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cam         (cam_r),
    .q_valid     (q_valid),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_point_z (out_point_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule
